// ----- sv/prds_pkg.sv -----
// Shared types and constants for the pixel replicate/decimate scaler.
package prds_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned CNT_W  = 12;
  localparam int unsigned ADDR_W = 15;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned REP_W  = 3;
  localparam int unsigned WID_W  = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE            = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_EXTRA    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_PERIOD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_EXTRA_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_EXTRA_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_PERIOD     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH        = 3'd6;

  // Scaling modes
  localparam logic MODE_ENLARGE = 1'b0;
  localparam logic MODE_SHRINK  = 1'b1;

  // Largest repeat count honored; a setting of seven acts as six
  localparam logic [REP_W-1:0] REP_MAX = 3'd6;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } prds_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] out_row;
    logic [ADDR_W-1:0] out_col;
    logic [PIX_W-1:0]  out_pixel;
    logic              run_last;
  } prds_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic emit;
  } prds_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic any;
    logic last;
    logic slot_free;
  } prds_sts_t;

endpackage

// ----- sv/pixel_replicate_decimate_scaler_unit.sv -----
// Top level of the nearest-neighbor pixel replicate/decimate scaler.
//
// Input channel in_valid/in_ready/in_data carries one raster pixel per
// transaction, frame_start set on the first pixel of a frame. Output channel
// out_valid/out_ready/out_data carries one copy per transaction with its
// output row and column; run_last marks the last copy of an input pixel.
// The cfg channel writes one register per transaction and is always ready;
// the user must write it only while the block is idle, as the block itself
// does not enforce this. An input transaction latches the pixel and its block
// size; each copy is then loaded into the output register, which raises
// out_valid. A pixel occupies the block until its last copy is loaded, and a
// dropped pixel still passes through the emit state. The copy counter in the
// datapath loads one copy per cycle into the output register while the
// receiver does not stall.
// Reset clears the scan counters and loads the register defaults.
// When the receiver stalls, the output register holds its copy and the copy
// counter waits; no new input is taken until the block is done.
module pixel_replicate_decimate_scaler_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  prds_pkg::prds_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output prds_pkg::prds_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [prds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prds_pkg::CFG_DATA_W-1:0] cfg_data
);
  import prds_pkg::*;

  prds_cmd_t cmd;
  prds_sts_t sts;

  assign cfg_ready = 1'b1;

  prds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prds_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  // An accepted pixel takes the block out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a block is still in progress");

  // The last copy of a block returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.last |=> in_ready)
    else $error("block did not finish after its last copy");

  // No copy is loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !cmd.emit)
    else $error("copy loaded over a stalled output");
`endif

endmodule

// ----- sv/prds_ctrl.sv -----
// Controller state machine: sequences accept and copy emission.
module prds_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  prds_pkg::prds_sts_t sts,
  output prds_pkg::prds_cmd_t cmd
);
  import prds_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r;
  logic state_nxt;

  // Accept only while idle; emit while the output slot is free
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd.accept = (state_r == ST_IDLE) && in_valid;
    cmd.emit   = (state_r == ST_EMIT) && sts.any && sts.slot_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.any || (cmd.emit && sts.last)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/prds_dp.sv -----
// Datapath: config registers, scan counters, block copy counters, output register.
module prds_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  prds_pkg::prds_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output prds_pkg::prds_out_t                 out_data,
  input  logic                                cfg_valid,
  input  logic [prds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [prds_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  prds_pkg::prds_cmd_t                 cmd,
  output prds_pkg::prds_sts_t                 sts
);
  import prds_pkg::*;

  // Next phase of a period counter
  function automatic logic [CNT_W-1:0] phase_next(input logic [CNT_W-1:0] ph,
                                                  input logic [CNT_W-1:0] per,
                                                  input logic             hit);
    logic [CNT_W-1:0] nxt;
    nxt = ph + 1'b1;
    if (per == '0 || hit) begin
      nxt = '0;
    end
    return nxt;
  endfunction

  // Configuration registers
  logic              mode_r;
  logic [REP_W-1:0]  repeat_extra_r;
  logic [CNT_W-1:0]  extra_period_r, col_extra_limit_r, row_extra_limit_r, drop_period_r;
  logic [WID_W-1:0]  in_width_r;

  // Scan state
  logic [CNT_W-1:0]  in_col_r, in_row_r, col_phase_r, row_phase_r;
  logic [CNT_W-1:0]  col_extras_used_r, row_extras_used_r;
  logic [ADDR_W-1:0] out_col_base_r, out_row_base_r;
  logic [CNT_W-1:0]  in_col_nxt, in_row_nxt, col_phase_nxt, row_phase_nxt;
  logic [CNT_W-1:0]  col_extras_used_nxt, row_extras_used_nxt;
  logic [ADDR_W-1:0] out_col_base_nxt, out_row_base_nxt;

  // Block being emitted
  logic [ADDR_W-1:0] blk_row_r, blk_col_r;
  logic [PIX_W-1:0]  pix_r;
  logic [REP_W-1:0]  ncm1_r, nrm1_r, r_r, c_r;
  logic              any_r, out_valid_r;
  logic [REP_W-1:0]  ncm1_nxt, nrm1_nxt;
  logic              any_nxt;
  prds_out_t         out_data_r;

  // Effective state after frame start clear
  logic [CNT_W-1:0]  in_col_e, in_row_e, col_phase_e, row_phase_e;
  logic [CNT_W-1:0]  col_used_e, row_used_e;
  logic [ADDR_W-1:0] col_base_e, row_base_e;
  logic [WID_W-1:0]  width_e;
  logic [REP_W-1:0]  rep;
  logic [CNT_W-1:0]  period;
  logic              col_hit, row_hit, col_more, row_more, row_end;
  logic [1:0]        nrows_shr;
  logic [REP_W:0]    ncols, nrows;
  logic              copy_last;

  // Decode one accepted pixel into a block and the updated scan state
  always_comb begin
    if (in_data.frame_start) begin
      in_col_e = '0; in_row_e = '0; col_phase_e = '0; row_phase_e = '0;
      col_used_e = '0; row_used_e = '0; col_base_e = '0; row_base_e = '0;
    end else begin
      in_col_e = in_col_r; in_row_e = in_row_r;
      col_phase_e = col_phase_r; row_phase_e = row_phase_r;
      col_used_e = col_extras_used_r; row_used_e = row_extras_used_r;
      col_base_e = out_col_base_r; row_base_e = out_row_base_r;
    end

    width_e = in_width_r;
    if (in_width_r == '0) begin
      width_e = WID_W'(1);
    end else if (in_width_r > WID_W'(MAX_WIDTH)) begin
      width_e = WID_W'(MAX_WIDTH);
    end
    rep    = (repeat_extra_r > REP_MAX) ? REP_MAX : repeat_extra_r;
    period = (mode_r == MODE_SHRINK) ? drop_period_r : extra_period_r;

    col_hit = (period != '0) && (({1'b0, col_phase_e} + 1'b1) >= {1'b0, period});
    row_hit = (period != '0) && (({1'b0, row_phase_e} + 1'b1) >= {1'b0, period});

    col_more  = 1'b0;
    row_more  = 1'b0;
    ncm1_nxt  = '0;
    nrm1_nxt  = '0;
    nrows_shr = row_hit ? 2'd0 : 2'd1;
    if (mode_r == MODE_ENLARGE) begin
      col_more = col_hit && (col_used_e < col_extra_limit_r);
      row_more = row_hit && (row_used_e < row_extra_limit_r);
      ncm1_nxt = rep + REP_W'(col_more);
      nrm1_nxt = rep + REP_W'(row_more);
      any_nxt  = 1'b1;
    end else begin
      any_nxt  = !col_hit && !row_hit;
    end
    ncols = {1'b0, ncm1_nxt} + 1'b1;
    nrows = (mode_r == MODE_ENLARGE) ? ({1'b0, nrm1_nxt} + 1'b1) : (REP_W + 1)'(nrows_shr);

    // Column advance
    col_extras_used_nxt = col_used_e + CNT_W'(col_more);
    if (mode_r == MODE_ENLARGE) begin
      out_col_base_nxt = col_base_e + ADDR_W'(ncols);
    end else begin
      out_col_base_nxt = col_base_e + ADDR_W'(!col_hit);
    end
    col_phase_nxt = phase_next(col_phase_e, period, col_hit);

    // Row end: clear column state, advance row state
    row_end             = (({1'b0, in_col_e} + 1'b1) >= width_e);
    in_row_nxt          = in_row_e;
    row_phase_nxt       = row_phase_e;
    row_extras_used_nxt = row_used_e;
    out_row_base_nxt    = row_base_e;
    in_col_nxt          = in_col_e + 1'b1;
    if (row_end) begin
      in_col_nxt          = '0;
      col_phase_nxt       = '0;
      col_extras_used_nxt = '0;
      out_col_base_nxt    = '0;
      row_extras_used_nxt = row_used_e + CNT_W'(row_more);
      out_row_base_nxt    = row_base_e + ADDR_W'(nrows);
      row_phase_nxt       = phase_next(row_phase_e, period, row_hit);
      in_row_nxt          = (({1'b0, in_row_e} + 1'b1) >= WID_W'(MAX_HEIGHT)) ?
                            '0 : (in_row_e + 1'b1);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r            <= MODE_ENLARGE;
      repeat_extra_r    <= '0;
      extra_period_r    <= '0;
      col_extra_limit_r <= '0;
      row_extra_limit_r <= '0;
      drop_period_r     <= CNT_W'(2);
      in_width_r        <= WID_W'(MAX_WIDTH);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:            mode_r            <= cfg_data[0];
        CFG_REPEAT_EXTRA:    repeat_extra_r    <= cfg_data[REP_W-1:0];
        CFG_EXTRA_PERIOD:    extra_period_r    <= cfg_data[CNT_W-1:0];
        CFG_COL_EXTRA_LIMIT: col_extra_limit_r <= cfg_data[CNT_W-1:0];
        CFG_ROW_EXTRA_LIMIT: row_extra_limit_r <= cfg_data[CNT_W-1:0];
        CFG_DROP_PERIOD:     drop_period_r     <= cfg_data[CNT_W-1:0];
        CFG_IN_WIDTH:        in_width_r        <= cfg_data[WID_W-1:0];
        default: ;
      endcase
    end
  end

  // Scan state update on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0; in_row_r <= '0; col_phase_r <= '0; row_phase_r <= '0;
      col_extras_used_r <= '0; row_extras_used_r <= '0;
      out_col_base_r <= '0; out_row_base_r <= '0;
      any_r <= 1'b0;
    end else if (cmd.accept) begin
      in_col_r          <= in_col_nxt;
      in_row_r          <= in_row_nxt;
      col_phase_r       <= col_phase_nxt;
      row_phase_r       <= row_phase_nxt;
      col_extras_used_r <= col_extras_used_nxt;
      row_extras_used_r <= row_extras_used_nxt;
      out_col_base_r    <= out_col_base_nxt;
      out_row_base_r    <= out_row_base_nxt;
      any_r             <= any_nxt;
    end
  end

  // Latch the block origin and size
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      blk_row_r <= row_base_e;
      blk_col_r <= col_base_e;
      pix_r     <= in_data.pixel;
      ncm1_r    <= ncm1_nxt;
      nrm1_r    <= nrm1_nxt;
    end
  end

  // Walk the block in row-major order
  assign copy_last = (r_r == nrm1_r) && (c_r == ncm1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r <= '0;
      c_r <= '0;
    end else if (cmd.accept) begin
      r_r <= '0;
      c_r <= '0;
    end else if (cmd.emit) begin
      if (c_r == ncm1_r) begin
        c_r <= '0;
        r_r <= r_r + 1'b1;
      end else begin
        c_r <= c_r + 1'b1;
      end
    end
  end

  // Output register: load a copy, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.out_row   <= blk_row_r + ADDR_W'(r_r);
      out_data_r.out_col   <= blk_col_r + ADDR_W'(c_r);
      out_data_r.out_pixel <= pix_r;
      out_data_r.run_last  <= copy_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.any       = any_r;
  assign sts.last      = copy_last;
  assign sts.slot_free = !out_valid_r || out_ready;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the pixel scaler: directed table and random settings.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import prds_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 300;
  localparam int unsigned LONG_HOLD = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  prds_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  prds_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_replicate_decimate_scaler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // One row of the directed table: a register write or a pixel, with an optional known copy
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    prds_in_t              px;
    bit                    typed;
    prds_out_t             want;
  } plan_row_t;

  plan_row_t plan[$];

  // Scaler settings as last written
  logic              cfg_mode;
  logic [REP_W-1:0]  cfg_repeat;
  logic [CNT_W-1:0]  cfg_extra_period;
  logic [CNT_W-1:0]  cfg_col_limit;
  logic [CNT_W-1:0]  cfg_row_limit;
  logic [CNT_W-1:0]  cfg_drop_period;
  logic [WID_W-1:0]  cfg_width;

  // Raster scan position, period phases, extras granted and output origin
  logic [CNT_W-1:0]  col_pos, row_pos, col_ph, row_ph, col_extra_cnt, row_extra_cnt;
  logic [ADDR_W-1:0] col_origin, row_origin;

  prds_out_t block_copies[$];
  prds_out_t copies_due[$];

  bit          calm;
  bit          hold_req;
  int unsigned faults;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic void fault(string msg);
    faults++;
    if (faults <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void clear_scan();
    col_pos = '0; row_pos = '0; col_ph = '0; row_ph = '0;
    col_extra_cnt = '0; row_extra_cnt = '0;
    col_origin = '0; row_origin = '0;
  endfunction

  function automatic bit period_due(logic [CNT_W-1:0] ph, int unsigned per);
    return per != 0 && ph + 1 >= per;
  endfunction

  function automatic logic [CNT_W-1:0] period_next(logic [CNT_W-1:0] ph, int unsigned per);
    return (per == 0 || ph + 1 >= per) ? '0 : ph + 1'b1;
  endfunction

  // Work out the copies one pixel produces and advance the scan
  function automatic void scale_pixel(prds_in_t d);
    int unsigned width, rep, per, ncols, nrows;
    bit col_hit, row_hit, col_more, row_more;
    prds_out_t c;
    block_copies.delete();
    if (d.frame_start) clear_scan();
    width = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
    rep = (cfg_repeat > REP_MAX) ? REP_MAX : cfg_repeat;
    per = (cfg_mode == MODE_SHRINK) ? cfg_drop_period : cfg_extra_period;
    col_hit = period_due(col_ph, per);
    row_hit = period_due(row_ph, per);
    col_more = 1'b0;
    row_more = 1'b0;
    if (cfg_mode == MODE_ENLARGE) begin
      col_more = col_hit && (col_extra_cnt < cfg_col_limit);
      row_more = row_hit && (row_extra_cnt < cfg_row_limit);
      ncols = rep + 1 + int'(col_more);
      nrows = rep + 1 + int'(row_more);
      for (int r = 0; r < nrows; r++) begin
        for (int k = 0; k < ncols; k++) begin
          c.out_row = ADDR_W'(row_origin + r);
          c.out_col = ADDR_W'(col_origin + k);
          c.out_pixel = d.pixel;
          c.run_last = (r + 1 == nrows) && (k + 1 == ncols);
          block_copies.push_back(c);
        end
      end
      if (col_more) col_extra_cnt = col_extra_cnt + 1'b1;
      col_origin = ADDR_W'(col_origin + ncols);
    end else begin
      // Drop the pixel when its column or row falls on the period
      nrows = row_hit ? 0 : 1;
      if (!col_hit && !row_hit) begin
        c.out_row = row_origin;
        c.out_col = col_origin;
        c.out_pixel = d.pixel;
        c.run_last = 1'b1;
        block_copies.push_back(c);
      end
      if (!col_hit) col_origin = col_origin + 1'b1;
    end
    col_ph = period_next(col_ph, per);
    // Wrap to the next row after the last input column
    if (col_pos + 1 >= width) begin
      col_pos = '0;
      col_ph = '0;
      col_extra_cnt = '0;
      col_origin = '0;
      if (row_more) row_extra_cnt = row_extra_cnt + 1'b1;
      row_origin = ADDR_W'(row_origin + nrows);
      row_ph = period_next(row_ph, per);
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.val = CFG_DATA_W'(val);
    return p;
  endfunction

  function automatic plan_row_t pix_row(logic [PIX_W-1:0] pix, bit fs);
    plan_row_t p;
    p = '0;
    p.px.pixel = pix;
    p.px.frame_start = fs;
    return p;
  endfunction

  // Pixel under default settings: a single copy at a position known by hand
  function automatic plan_row_t known_row(logic [PIX_W-1:0] pix, bit fs, int unsigned row,
                                          int unsigned col);
    plan_row_t p;
    p = pix_row(pix, fs);
    p.typed = 1'b1;
    p.want.out_row = ADDR_W'(row);
    p.want.out_col = ADDR_W'(col);
    p.want.out_pixel = pix;
    p.want.run_last = 1'b1;
    return p;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_setting(int unsigned small_hi,
                                                         int unsigned top);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_DATA_W'(1);
      2: return CFG_DATA_W'(top);
      default: return CFG_DATA_W'($urandom_range(1, small_hi));
    endcase
  endfunction

  // Write one register; the caller lowers cfg_valid after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE:            cfg_mode = val[0];
      CFG_REPEAT_EXTRA:    cfg_repeat = val[REP_W-1:0];
      CFG_EXTRA_PERIOD:    cfg_extra_period = val[CNT_W-1:0];
      CFG_COL_EXTRA_LIMIT: cfg_col_limit = val[CNT_W-1:0];
      CFG_ROW_EXTRA_LIMIT: cfg_row_limit = val[CNT_W-1:0];
      CFG_DROP_PERIOD:     cfg_drop_period = val[CNT_W-1:0];
      CFG_IN_WIDTH:        cfg_width = val[WID_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one pixel after a random gap and queue its copies once accepted
  task automatic send_pixel(input prds_in_t d, input bit typed, input prds_out_t want);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    scale_pixel(d);
    if (typed) begin
      copies_due.push_back(want);
    end else begin
      foreach (block_copies[i]) copies_due.push_back(block_copies[i]);
    end
  endtask

  // Drain all copies, then give a dropped pixel time to clear the block
  task automatic settle();
    in_valid <= 1'b0;
    while (copies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic take_copy(input prds_out_t got);
    prds_out_t want;
    if (copies_due.size() == 0) begin
      fault($sformatf("unexpected copy row %0d col %0d pixel %02h last %0b",
                      got.out_row, got.out_col, got.out_pixel, got.run_last));
    end else begin
      want = copies_due.pop_front();
      if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
          got.out_pixel !== want.out_pixel || got.run_last !== want.run_last)
        fault($sformatf("expected row %0d col %0d pixel %02h last %0b, got %0d %0d %02h %0b",
                        want.out_row, want.out_col, want.out_pixel, want.run_last,
                        got.out_row, got.out_col, got.out_pixel, got.run_last));
    end
  endtask

  // Receiver: random stalls per copy, one long hold-off on request
  initial begin : drain
    int unsigned stall;
    bit held;
    out_ready = 1'b0;
    held = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req && !held) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held = 1'b1;
      end
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      take_copy(out_data);
    end
  end

  initial begin : stimulus
    prds_in_t d;
    int unsigned sent, n, missing;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    faults = 0;
    cfg_mode = MODE_ENLARGE;
    cfg_repeat = '0;
    cfg_extra_period = '0;
    cfg_col_limit = '0;
    cfg_row_limit = '0;
    cfg_drop_period = CNT_W'(2);
    cfg_width = WID_W'(MAX_WIDTH);
    clear_scan();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults after reset: one copy per pixel; a frame start restarts the raster
    plan.push_back(known_row(8'h00, 1'b1, 0, 0));
    plan.push_back(known_row(8'hFF, 1'b0, 0, 1));
    plan.push_back(known_row(8'hA5, 1'b1, 0, 0));
    plan.push_back(known_row(8'h5A, 1'b0, 0, 1));
    // Enlarge 2x on a three-pixel row, one extra column per row and one extra row
    plan.push_back(reg_row(CFG_IN_WIDTH, 3));
    plan.push_back(reg_row(CFG_REPEAT_EXTRA, 1));
    plan.push_back(reg_row(CFG_EXTRA_PERIOD, 2));
    plan.push_back(reg_row(CFG_COL_EXTRA_LIMIT, 1));
    plan.push_back(reg_row(CFG_ROW_EXTRA_LIMIT, 1));
    plan.push_back(pix_row(8'h11, 1'b1));
    for (int i = 0; i < 5; i++) plan.push_back(pix_row(PIX_W'(8'h20 + i), 1'b0));
    // Largest block: repeat of seven acts as six, extra column and row on every pixel
    plan.push_back(reg_row(CFG_REPEAT_EXTRA, 7));
    plan.push_back(reg_row(CFG_EXTRA_PERIOD, 1));
    plan.push_back(reg_row(CFG_COL_EXTRA_LIMIT, 4095));
    plan.push_back(reg_row(CFG_ROW_EXTRA_LIMIT, 4095));
    plan.push_back(reg_row(CFG_IN_WIDTH, 2));
    plan.push_back(pix_row(8'hC3, 1'b1));
    plan.push_back(pix_row(8'h3C, 1'b0));
    // Shrink: drop every third column and row
    plan.push_back(reg_row(CFG_MODE, MODE_SHRINK));
    plan.push_back(reg_row(CFG_DROP_PERIOD, 3));
    plan.push_back(reg_row(CFG_IN_WIDTH, 4));
    plan.push_back(pix_row(8'h81, 1'b1));
    for (int i = 0; i < 7; i++) plan.push_back(pix_row(PIX_W'(8'h40 + i), 1'b0));
    // Drop period of one drops everything
    plan.push_back(reg_row(CFG_DROP_PERIOD, 1));
    plan.push_back(pix_row(8'h77, 1'b0));
    plan.push_back(pix_row(8'h88, 1'b0));
    // Drop period of zero never drops; width zero acts as one
    plan.push_back(reg_row(CFG_DROP_PERIOD, 0));
    plan.push_back(reg_row(CFG_IN_WIDTH, 0));
    plan.push_back(pix_row(8'h99, 1'b1));
    plan.push_back(pix_row(8'h66, 1'b0));
    // Width beyond the maximum clamps; longest extra period
    plan.push_back(reg_row(CFG_MODE, MODE_ENLARGE));
    plan.push_back(reg_row(CFG_REPEAT_EXTRA, 0));
    plan.push_back(reg_row(CFG_EXTRA_PERIOD, 4095));
    plan.push_back(reg_row(CFG_IN_WIDTH, 8191));
    plan.push_back(pix_row(8'hE7, 1'b0));

    // Walk the table; settle the block before each group of writes
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!cfg_valid) settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        send_pixel(plan[i].px, plan[i].typed, plan[i].want);
      end
    end

    // Random settings, each followed by a run of mostly well-formed raster
    sent = 0;
    for (int p = 0; sent < RANDOM_PIXELS; p++) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      write_reg(CFG_MODE, (p == 0) ? CFG_DATA_W'(MODE_ENLARGE)
                                   : CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(CFG_REPEAT_EXTRA, pick_setting(2, 6 + $urandom_range(0, 1)));
      write_reg(CFG_EXTRA_PERIOD, pick_setting(4, 4095));
      write_reg(CFG_COL_EXTRA_LIMIT, pick_setting(3, 4095));
      write_reg(CFG_ROW_EXTRA_LIMIT, pick_setting(3, 4095));
      write_reg(CFG_DROP_PERIOD, pick_setting(5, 4095));
      write_reg(CFG_IN_WIDTH, pick_setting(8, 8191));
      cfg_valid <= 1'b0;
      // Hold the receiver off once so the block fills and stalls its input
      if (p == 0) hold_req = 1'b1;
      n = $urandom_range(10, 40);
      for (int k = 0; k < n; k++) begin
        d.pixel = PIX_W'($urandom);
        d.frame_start = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0);
        send_pixel(d, 1'b0, '0);
        sent++;
      end
    end

    // Drain, then keep waiting for any stray copies
    in_valid <= 1'b0;
    for (int k = 0; k < 100000 && copies_due.size() != 0; k++) @(posedge clk);
    repeat (16) @(posedge clk);
    missing = copies_due.size();
    if (missing != 0) $display("mismatch: %0d expected copies never arrived", missing);
    if (faults == 0 && missing == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/prds_pkg.sv
sv/prds_ctrl.sv
sv/prds_dp.sv
sv/pixel_replicate_decimate_scaler_unit.sv
bench/testbench.sv
